@@ rtl/fsa_pkg.sv @@
`default_nettype none
package fsa_pkg;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_NEXT  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seg_address;
        logic [31:0] seg_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
        logic [31:0] granted_length;
    } t_rsp;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
    } t_seg;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_SPLIT,
        FIN_EXACT,
        FIN_BOTH,
        FIN_INS
    } t_fin;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_EV   = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_SHR  = 8'b0001_0000,
        S_SHW  = 8'b0010_0000,
        S_WR   = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

@@ rtl/fsa_ram.sv @@
`default_nettype none
module fsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/free_segment_allocator.sv @@
// channel   | direction | handshake                    | payload
// request   | in        | start, busy                  | i_req (cmd, seg_address, seg_length)
// result    | out       | o_result_valid, one cycle    | o_result (status, address, length)
// config    | in        | i_cfg_valid, o_cfg_ready     | i_cfg_data (fit policy)
//
// one item at a time: the scan reads one table entry after another through the
// single ram read port, in S_RD and S_EV; a remove or insert then moves the entries
// behind the slot one by one through S_SHR and S_SHW
// synchronous reset clears the state, policy, count, rover and result strobe; the table needs no clearing pass
// the result strobe lasts one cycle and cannot be stalled
`default_nettype none
module free_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire fsa_pkg::t_req i_req,
    output logic              o_result_valid,
    output fsa_pkg::t_rsp     o_result,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_data
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

    fsa_pkg::t_state r_state, n_state;
    fsa_pkg::t_req   r_req, n_req;
    fsa_pkg::t_fin   r_fin, n_fin;
    fsa_pkg::t_seg   r_lft, n_lft, r_rgt, n_rgt, r_wr_data, n_wr_data;
    fsa_pkg::t_seg   rd_seg;
    fsa_pkg::t_rsp   r_res, n_res;
    logic [1:0]      r_policy, n_policy, r_status, n_status;
    logic [CW-1:0]   r_cnt, n_cnt, r_i, n_i, r_k, n_k, r_sel, n_sel, r_p, n_p, r_j, n_j;
    logic [AW-1:0]   r_rover, n_rover, r_wr_idx, n_wr_idx;
    logic [31:0]     r_sel_start, n_sel_start, r_sel_size, n_sel_size;
    logic            r_have, n_have, r_lft_v, n_lft_v, r_rgt_v, n_rgt_v;
    logic            r_up, n_up, r_wr_en, n_wr_en, r_res_v, n_res_v;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [63:0]     ram_wdata, ram_rdata;

    fsa_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_seg         = fsa_pkg::t_seg'(ram_rdata);
    assign busy           = (r_state != fsa_pkg::S_IDLE);
    assign o_cfg_ready    = (r_state == fsa_pkg::S_IDLE);
    assign o_result_valid = r_res_v;
    assign o_result       = r_res;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_idx;
        ram_wdata = r_wr_data;
        ram_raddr = r_i[AW-1:0];
        if (r_state == fsa_pkg::S_SHR) begin
            ram_raddr = r_up ? AW'(r_j - ONE_C) : r_j[AW-1:0];
        end
        if (r_state == fsa_pkg::S_SHW) begin
            ram_we    = 1'b1;
            ram_waddr = r_up ? r_j[AW-1:0] : AW'(r_j - ONE_C);
            ram_wdata = ram_rdata;
        end
        if (r_state == fsa_pkg::S_WR) begin
            ram_we = 1'b1;
        end
    end

    logic [31:0]   ln;
    logic          last, take, upd, have_n;
    logic [CW-1:0] t_sel;
    logic [31:0]   t_start, t_size;
    logic [32:0]   sum_l, sum_r, end_a, lft_end;
    logic [33:0]   sum_3;
    logic          ml, mr, both;
    logic [CW-1:0] rv;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_fin       = r_fin;
        n_lft       = r_lft;
        n_rgt       = r_rgt;
        n_wr_data   = r_wr_data;
        n_res       = r_res;
        n_policy    = r_policy;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_k         = r_k;
        n_sel       = r_sel;
        n_p         = r_p;
        n_j         = r_j;
        n_rover     = r_rover;
        n_wr_idx    = r_wr_idx;
        n_sel_start = r_sel_start;
        n_sel_size  = r_sel_size;
        n_have      = r_have;
        n_lft_v     = r_lft_v;
        n_rgt_v     = r_rgt_v;
        n_up        = r_up;
        n_wr_en     = r_wr_en;
        n_res_v     = 1'b0;

        ln      = r_req.seg_length;
        last    = (r_k + ONE_C == r_cnt);
        take    = 1'b0;
        upd     = 1'b0;
        have_n  = r_have;
        t_sel   = r_sel;
        t_start = r_sel_start;
        t_size  = r_sel_size;
        lft_end = {1'b0, r_lft.start} + {1'b0, r_lft.size};
        sum_l   = {1'b0, r_lft.size} + {1'b0, ln};
        sum_r   = {1'b0, r_rgt.size} + {1'b0, ln};
        end_a   = {1'b0, r_req.seg_address} + {1'b0, ln};
        sum_3   = {2'b0, r_lft.size} + {2'b0, ln} + {2'b0, r_rgt.size};
        ml      = r_lft_v && (lft_end == {1'b0, r_req.seg_address}) && !sum_l[32];
        mr      = r_rgt_v && (end_a == {1'b0, r_rgt.start}) && !sum_r[32];
        both    = ml && mr && (sum_3[33:32] == 2'b00);
        rv      = CW'(r_rover);

        if (i_cfg_valid && o_cfg_ready) begin
            n_policy = i_cfg_data;
        end

        unique case (r_state)
            fsa_pkg::S_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_k      = '0;
                    n_have   = 1'b0;
                    n_lft_v  = 1'b0;
                    n_rgt_v  = 1'b0;
                    n_wr_en  = 1'b0;
                    n_fin    = fsa_pkg::FIN_NONE;
                    n_status = fsa_pkg::ST_OK;
                    n_i      = (r_policy == fsa_pkg::POL_NEXT && i_req.cmd == fsa_pkg::CMD_ALLOC)
                               ? rv : '0;
                    if (i_req.cmd == fsa_pkg::CMD_ALLOC) begin
                        if (i_req.seg_length == '0 || r_cnt == '0) begin
                            n_status = fsa_pkg::ST_NOFIT;
                            n_state  = fsa_pkg::S_FIN;
                        end else begin
                            n_state = fsa_pkg::S_RD;
                        end
                    end else if (i_req.seg_length == '0) begin
                        n_state = fsa_pkg::S_FIN;
                    end else if (r_cnt == '0) begin
                        n_p     = '0;
                        n_state = fsa_pkg::S_DEC;
                    end else begin
                        n_state = fsa_pkg::S_RD;
                    end
                end
            end
            fsa_pkg::S_RD: begin
                n_state = fsa_pkg::S_EV;
            end
            fsa_pkg::S_EV: begin
                if (r_req.cmd == fsa_pkg::CMD_FREE) begin
                    if (rd_seg.start <= r_req.seg_address) begin
                        n_lft   = rd_seg;
                        n_lft_v = 1'b1;
                        n_i     = r_i + ONE_C;
                        if (r_i + ONE_C == r_cnt) begin
                            n_p     = r_i + ONE_C;
                            n_state = fsa_pkg::S_DEC;
                        end else begin
                            n_state = fsa_pkg::S_RD;
                        end
                    end else begin
                        n_rgt   = rd_seg;
                        n_rgt_v = 1'b1;
                        n_p     = r_i;
                        n_state = fsa_pkg::S_DEC;
                    end
                end else if (r_policy == fsa_pkg::POL_BEST) begin
                    if (rd_seg.size == ln) begin
                        take    = 1'b1;
                        t_sel   = r_i;
                        t_start = rd_seg.start;
                        t_size  = rd_seg.size;
                    end else begin
                        upd    = (rd_seg.size > ln) && (!r_have || rd_seg.size < r_sel_size);
                        have_n = r_have || upd;
                        if (upd) begin
                            t_sel   = r_i;
                            t_start = rd_seg.start;
                            t_size  = rd_seg.size;
                        end
                        n_have      = have_n;
                        n_sel       = t_sel;
                        n_sel_start = t_start;
                        n_sel_size  = t_size;
                        if (last) begin
                            take = have_n;
                            if (!have_n) begin
                                n_status = fsa_pkg::ST_NOFIT;
                                n_state  = fsa_pkg::S_FIN;
                            end
                        end else begin
                            n_i     = r_i + ONE_C;
                            n_k     = r_k + ONE_C;
                            n_state = fsa_pkg::S_RD;
                        end
                    end
                end else begin
                    if (rd_seg.size >= ln) begin
                        take    = 1'b1;
                        t_sel   = r_i;
                        t_start = rd_seg.start;
                        t_size  = rd_seg.size;
                    end else if (last) begin
                        n_status = fsa_pkg::ST_NOFIT;
                        n_state  = fsa_pkg::S_FIN;
                    end else begin
                        n_k     = r_k + ONE_C;
                        n_i     = (r_policy == fsa_pkg::POL_NEXT && r_i + ONE_C == r_cnt)
                                  ? '0 : r_i + ONE_C;
                        n_state = fsa_pkg::S_RD;
                    end
                end
                if (take) begin
                    n_sel       = t_sel;
                    n_sel_start = t_start;
                    n_sel_size  = t_size;
                    if (t_size == ln) begin
                        n_fin   = fsa_pkg::FIN_EXACT;
                        n_wr_en = 1'b0;
                        n_up    = 1'b0;
                        n_j     = t_sel + ONE_C;
                        n_state = (t_sel + ONE_C < r_cnt) ? fsa_pkg::S_SHR : fsa_pkg::S_FIN;
                    end else begin
                        n_fin     = fsa_pkg::FIN_SPLIT;
                        n_wr_en   = 1'b1;
                        n_wr_idx  = t_sel[AW-1:0];
                        n_wr_data = '{start: t_start + ln, size: t_size - ln};
                        n_state   = fsa_pkg::S_WR;
                    end
                end
            end
            fsa_pkg::S_DEC: begin
                n_wr_en = 1'b1;
                n_state = fsa_pkg::S_WR;
                if (both) begin
                    n_fin     = fsa_pkg::FIN_BOTH;
                    n_wr_idx  = AW'(r_p - ONE_C);
                    n_wr_data = '{start: r_lft.start, size: sum_3[31:0]};
                    n_up      = 1'b0;
                    n_j       = r_p + ONE_C;
                    if (r_p + ONE_C < r_cnt) begin
                        n_state = fsa_pkg::S_SHR;
                    end
                end else if (ml) begin
                    n_wr_idx  = AW'(r_p - ONE_C);
                    n_wr_data = '{start: r_lft.start, size: sum_l[31:0]};
                end else if (mr) begin
                    n_wr_idx  = r_p[AW-1:0];
                    n_wr_data = '{start: r_req.seg_address, size: sum_r[31:0]};
                end else if (r_cnt >= MAX_C) begin
                    n_wr_en  = 1'b0;
                    n_status = fsa_pkg::ST_FULL;
                    n_state  = fsa_pkg::S_FIN;
                end else begin
                    n_fin     = fsa_pkg::FIN_INS;
                    n_wr_idx  = r_p[AW-1:0];
                    n_wr_data = '{start: r_req.seg_address, size: ln};
                    n_up      = 1'b1;
                    n_j       = r_cnt;
                    if (r_cnt > r_p) begin
                        n_state = fsa_pkg::S_SHR;
                    end
                end
            end
            fsa_pkg::S_SHR: begin
                n_state = fsa_pkg::S_SHW;
            end
            fsa_pkg::S_SHW: begin
                if (r_up) begin
                    n_j     = r_j - ONE_C;
                    n_state = (r_j - ONE_C > r_p) ? fsa_pkg::S_SHR
                            : (r_wr_en ? fsa_pkg::S_WR : fsa_pkg::S_FIN);
                end else begin
                    n_j     = r_j + ONE_C;
                    n_state = (r_j + ONE_C < r_cnt) ? fsa_pkg::S_SHR
                            : (r_wr_en ? fsa_pkg::S_WR : fsa_pkg::S_FIN);
                end
            end
            fsa_pkg::S_WR: begin
                n_state = fsa_pkg::S_FIN;
            end
            fsa_pkg::S_FIN: begin
                unique case (r_fin)
                    fsa_pkg::FIN_EXACT: begin
                        n_cnt = r_cnt - ONE_C;
                        if (r_policy == fsa_pkg::POL_NEXT) begin
                            rv = r_sel;
                        end else if (r_sel < rv) begin
                            rv = rv - ONE_C;
                        end
                    end
                    fsa_pkg::FIN_SPLIT: begin
                        if (r_policy == fsa_pkg::POL_NEXT) begin
                            rv = r_sel;
                        end
                    end
                    fsa_pkg::FIN_BOTH: begin
                        n_cnt = r_cnt - ONE_C;
                        if (rv >= r_p) begin
                            rv = rv - ONE_C;
                        end
                    end
                    fsa_pkg::FIN_INS: begin
                        n_cnt = r_cnt + ONE_C;
                        if (r_cnt != '0 && r_p <= rv) begin
                            rv = rv + ONE_C;
                        end
                    end
                    default: begin
                    end
                endcase
                if (rv >= n_cnt) begin
                    rv = '0;
                end
                n_rover = rv[AW-1:0];
                n_res_v = 1'b1;
                n_res.status = r_status;
                if (r_req.cmd == fsa_pkg::CMD_ALLOC && r_status == fsa_pkg::ST_OK) begin
                    n_res.granted_address = r_sel_start;
                    n_res.granted_length  = ln;
                end else begin
                    n_res.granted_address = '0;
                    n_res.granted_length  = '0;
                end
                n_state = fsa_pkg::S_IDLE;
            end
            default: begin
                n_state = fsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fsa_pkg::S_IDLE;
            r_policy <= fsa_pkg::POL_FIRST;
            r_cnt    <= '0;
            r_rover  <= '0;
            r_res_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_policy <= n_policy;
            r_cnt    <= n_cnt;
            r_rover  <= n_rover;
            r_res_v  <= n_res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_fin       <= n_fin;
        r_lft       <= n_lft;
        r_rgt       <= n_rgt;
        r_wr_data   <= n_wr_data;
        r_res       <= n_res;
        r_status    <= n_status;
        r_i         <= n_i;
        r_k         <= n_k;
        r_sel       <= n_sel;
        r_p         <= n_p;
        r_j         <= n_j;
        r_wr_idx    <= n_wr_idx;
        r_sel_start <= n_sel_start;
        r_sel_size  <= n_sel_size;
        r_have      <= n_have;
        r_lft_v     <= n_lft_v;
        r_rgt_v     <= n_rgt_v;
        r_up        <= n_up;
        r_wr_en     <= n_wr_en;
    end

endmodule
`default_nettype wire

@@ rtl/fsa_checker.sv @@
`default_nettype none
module fsa_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire fsa_pkg::t_req i_req,
    input wire logic          o_result_valid,
    input wire fsa_pkg::t_rsp o_result,
    input wire logic          i_cfg_valid,
    input wire logic          o_cfg_ready,
    input wire logic [1:0]    i_cfg_data
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // a result only ends a busy stretch
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy) && !busy)
        else $error("result without preceding work");

    // one result per item
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // failed items grant nothing; this property does not check items that succeed
    a_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status != fsa_pkg::ST_OK |->
            o_result.granted_address == '0 && o_result.granted_length == '0)
        else $error("grant fields set on error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result.status == fsa_pkg::ST_OK ||
            o_result.status == fsa_pkg::ST_NOFIT || o_result.status == fsa_pkg::ST_FULL)
        else $error("unknown status code");

endmodule

bind free_segment_allocator fsa_checker u_fsa_checker (.*);
`default_nettype wire

@@ tb/free_segment_allocator_checker.sv @@
`default_nettype none
module free_segment_allocator_checker #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire fsa_pkg::t_req i_req,
    input  wire logic          o_result_valid,
    input  wire fsa_pkg::t_rsp o_result,
    input  wire logic          i_cfg_valid,
    input  wire logic          o_cfg_ready,
    input  wire logic [1:0]    i_cfg_data,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fsa_pkg::*;

    logic [31:0] seg_start [MAX_SEGMENTS];
    logic [31:0] seg_size  [MAX_SEGMENTS];
    int          seg_count;
    int          rover;
    logic [1:0]  policy;
    t_rsp        grant_queue [$];

    assign pending_count = grant_queue.size();

    function automatic void drop_seg(int r);
        for (int i = r; i + 1 < seg_count; i++) begin
            seg_start[i] = seg_start[i + 1];
            seg_size[i]  = seg_size[i + 1];
        end
        seg_count--;
    endfunction

    function automatic void rover_wrap();
        if (rover >= seg_count) rover = 0;
    endfunction

    function automatic logic [1:0] release_seg(logic [31:0] a, logic [31:0] n);
        int p;
        logic ml, mr;
        logic [33:0] tot;
        p  = 0;
        ml = 1'b0;
        mr = 1'b0;
        if (n == 0) return ST_OK;
        while (p < seg_count && seg_start[p] <= a) p++;
        if (p > 0)
            ml = ({1'b0, seg_start[p-1]} + seg_size[p-1] == {1'b0, a}) &&
                 ({1'b0, seg_size[p-1]} + n <= 33'hFFFF_FFFF);
        if (p < seg_count)
            mr = ({1'b0, a} + n == {1'b0, seg_start[p]}) &&
                 ({1'b0, seg_size[p]} + n <= 33'hFFFF_FFFF);
        if (ml && mr) tot = {2'b0, seg_size[p-1]} + n + seg_size[p];
        else tot = '1;
        if (ml && mr && tot <= 34'hFFFF_FFFF) begin
            seg_size[p-1] = tot[31:0];
            drop_seg(p);
            if (rover >= p) rover--;
            rover_wrap();
        end else if (ml) begin
            seg_size[p-1] += n;
        end else if (mr) begin
            seg_start[p] = a;
            seg_size[p] += n;
        end else begin
            if (seg_count >= MAX_SEGMENTS) return ST_FULL;
            for (int i = seg_count; i > p; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_size[i]  = seg_size[i-1];
            end
            seg_start[p] = a;
            seg_size[p]  = n;
            if (seg_count > 0 && p <= rover) rover++;
            seg_count++;
            rover_wrap();
        end
        return ST_OK;
    endfunction

    function automatic int pick_seg(logic [31:0] n);
        int best, i;
        best = -1;
        if (policy == POL_BEST) begin
            for (i = 0; i < seg_count; i++) begin
                if (seg_size[i] == n) return i;
                if (seg_size[i] > n && (best < 0 || seg_size[i] < seg_size[best])) best = i;
            end
            return best;
        end
        if (policy == POL_NEXT) begin
            rover_wrap();
            i = rover;
            for (int k = 0; k < seg_count; k++) begin
                if (seg_size[i] >= n) return i;
                i++;
                if (i >= seg_count) i = 0;
            end
            return -1;
        end
        for (i = 0; i < seg_count; i++)
            if (seg_size[i] >= n) return i;
        return -1;
    endfunction

    function automatic t_rsp serve_request(t_req q);
        t_rsp r;
        int   idx;
        r = '0;
        if (q.cmd == CMD_FREE) begin
            r.status = release_seg(q.seg_address, q.seg_length);
            return r;
        end
        idx = (q.seg_length == 0) ? -1 : pick_seg(q.seg_length);
        if (idx < 0) begin
            r.status = ST_NOFIT;
            return r;
        end
        r.status = ST_OK;
        r.granted_address = seg_start[idx];
        r.granted_length  = q.seg_length;
        if (seg_size[idx] == q.seg_length) begin
            drop_seg(idx);
            if (policy == POL_NEXT) rover = idx;
            else if (idx < rover) rover--;
        end else begin
            seg_start[idx] += q.seg_length;
            seg_size[idx]  -= q.seg_length;
            if (policy == POL_NEXT) rover = idx;
        end
        rover_wrap();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            seg_count  = 0;
            rover      = 0;
            policy     = POL_FIRST;
            fail_count <= 0;
            grant_queue.delete();
        end else begin
            if (o_result_valid) begin
                if (grant_queue.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h", $time, o_result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = grant_queue.pop_front();
                    if (want.status !== o_result.status ||
                        want.granted_address !== o_result.granted_address ||
                        want.granted_length !== o_result.granted_length) begin
                        $display("%0t result: expected st=%0d a=%h l=%h, actual st=%0d a=%h l=%h",
                                 $time, want.status, want.granted_address,
                                 want.granted_length, o_result.status,
                                 o_result.granted_address, o_result.granted_length);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) grant_queue.push_back(serve_request(i_req));
            if (i_cfg_valid && o_cfg_ready) policy = i_cfg_data;
        end
    end
endmodule
`default_nettype wire

@@ tb/free_segment_allocator_tb.sv @@
`default_nettype none
module free_segment_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsa_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_req       req;
    logic       result_valid;
    t_rsp       result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending_count;
    logic       no_idle;

    free_segment_allocator u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    free_segment_allocator_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic issue(logic c, logic [31:0] a, logic [31:0] n);
        while (!no_idle && $urandom_range(99) < 25) @(posedge clk);
        start <= 1'b1;
        req   <= '{cmd: c, seg_address: a, seg_length: n};
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        req   <= '{cmd: 1'($urandom), seg_address: $urandom, seg_length: $urandom};
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random item biased toward a small arena so frees merge and allocs fit
    task automatic random_item();
        int          r;
        logic [31:0] a, n;
        r = $urandom_range(99);
        if (r < 45) begin
            a = $urandom_range(255) * 16;
            n = $urandom_range(1, 4) * 16;
            issue(CMD_FREE, a, n);
        end else if (r < 85) begin
            issue(CMD_ALLOC, $urandom, $urandom_range(1, 4) * 16);
        end else if (r < 90) begin
            issue(CMD_ALLOC, $urandom, $urandom_range(1, 15));
        end else if (r < 95) begin
            issue(1'($urandom_range(1)), $urandom, $urandom);
        end else begin
            issue(1'($urandom_range(1)), $urandom, 32'h0);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = POL_FIRST;
        no_idle   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_ALLOC, 32'hFFFF_FFFF, 32'd16);
        issue(CMD_FREE, 32'h0000_1000, 32'h0000_0100);
        issue(CMD_FREE, 32'h0000_1200, 32'h0000_0100);
        issue(CMD_FREE, 32'h0000_1100, 32'h0000_0100);
        issue(CMD_FREE, 32'h0000_0F00, 32'h0000_0100);
        issue(CMD_FREE, 32'h0000_1300, 32'h0000_0100);
        issue(CMD_FREE, 32'h0000_2000, 32'h0);
        issue(CMD_ALLOC, 32'h0, 32'h0);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0500);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0100);
        issue(CMD_FREE, 32'h0, 32'h8000_0000);
        issue(CMD_FREE, 32'h8000_0000, 32'h8000_0000);
        issue(CMD_FREE, 32'hFFFF_FFFF, 32'h0000_0001);
        issue(CMD_FREE, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);
        issue(CMD_ALLOC, 32'h0, 32'h8000_0000);
        set_policy(POL_BEST);
        issue(CMD_FREE, 32'h0000_0010, 32'h0000_0020);
        issue(CMD_FREE, 32'h0000_0100, 32'h0000_0010);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0010);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0008);
        set_policy(POL_NEXT);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0004);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0004);
        set_policy(2'd3);
        issue(CMD_ALLOC, 32'h0, 32'h0000_0004);

        // fill the table with isolated segments to reach the full case
        set_policy(POL_FIRST);
        no_idle = 1'b1;
        for (int i = 0; i < 70; i++) issue(CMD_FREE, 32'h4000_0000 + i * 8, 32'd4);
        no_idle = 1'b0;
        drain();
        issue(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            set_policy(ph[1:0]);
            for (int i = 0; i < 100; i++) begin
                no_idle = (ph == 1 && i >= 40 && i < 80);
                random_item();
            end
        end
        no_idle = 1'b0;

        drain();
        if (fail_count == 0) begin
            $display("free_segment_allocator: match");
        end else begin
            $display("free_segment_allocator: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("free_segment_allocator: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
